// File: hdl/gdof_pkg.sv
// shared types and constants of the overlap filter
`timescale 1ns / 1ps
package gdof_pkg;

  localparam int ETA_W  = 16;
  localparam int PHI_W  = 15;
  localparam int THR_W  = 15;
  localparam int SLOT_W = 4;
  localparam int DE_W   = ETA_W + 1;
  localparam int FOLD_W = 18;
  localparam int DE_SQ_W  = 2 * ETA_W;
  localparam int DP_SQ_W  = 2 * PHI_W;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int SUM_W    = DE_SQ_W + 1;

  localparam int PI_Q20 = 3294199;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1638;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
  } gdof_cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } gdof_sts_t;

endpackage

// File: hdl/gdof_datapath.sv
// list memory, distance compare pipeline and threshold register
`timescale 1ns / 1ps
module gdof_datapath import gdof_pkg::*; #(
  parameter int MAX_KEPT  = 16,
  parameter int FRAC_BITS = 12,
  parameter int AW        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [ETA_W-1:0]  in_eta,
  input  logic        [PHI_W-1:0]  in_phi,
  input  logic                     cfg_wr,
  input  logic        [THR_W-1:0]  cfg_min_distance,
  input  gdof_cmd_t                cmd,
  input  logic        [AW-1:0]     addr,
  output gdof_sts_t                sts
);

  localparam int PI_Q     = (PI_Q20 + (1 << (19 - FRAC_BITS))) >> (20 - FRAC_BITS);
  localparam int TWO_PI_Q = 2 * PI_Q;
  localparam logic [FOLD_W-1:0] PI_QV     = FOLD_W'(PI_Q);
  localparam logic [FOLD_W-1:0] TWO_PI_QV = FOLD_W'(TWO_PI_Q);

  logic [ETA_W+PHI_W-1:0] mem [MAX_KEPT];

  logic        [THR_W-1:0]    thr_r;
  logic        [THR_SQ_W-1:0] thr_sq_r;
  logic signed [ETA_W-1:0]    obj_eta_r;
  logic        [PHI_W-1:0]    obj_phi_r;
  logic signed [ETA_W-1:0]    rd_eta_r;
  logic        [PHI_W-1:0]    rd_phi_r;
  logic signed [DE_W-1:0]     de_r;
  logic signed [DE_W-1:0]     de_nxt;
  logic        [PHI_W-1:0]    dpa_r;
  logic        [PHI_W-1:0]    dpa_nxt;
  logic signed [DE_W-1:0]     de2_r;
  logic        [PHI_W-1:0]    dpf_r;
  logic        [PHI_W-1:0]    dpf_nxt;
  logic        [DE_SQ_W-1:0]  de_sq_r;
  logic        [DP_SQ_W-1:0]  dp_sq_r;
  logic signed [2*DE_W-1:0]   de_prod;
  logic        [FOLD_W-1:0]   dpa_ext;
  logic        [FOLD_W-1:0]   fold_up;
  logic        [FOLD_W-1:0]   fold_dn;
  logic        [SUM_W-1:0]    dist_sq;
  logic                       close;
  logic                       v1_r, v2_r, v3_r, v4_r;
  logic                       hit_r;

  // threshold register and its square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr) begin
      thr_r <= cfg_min_distance;
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= thr_r * thr_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obj_eta_r <= in_eta;
      obj_phi_r <= in_phi;
    end
  end

  // list memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= {obj_eta_r, obj_phi_r};
    end
    if (cmd.rd_en) begin
      {rd_eta_r, rd_phi_r} <= mem[addr];
    end
  end

  // stage 1: differences
  always_comb begin
    de_nxt = $signed({obj_eta_r[ETA_W-1], obj_eta_r}) - $signed({rd_eta_r[ETA_W-1], rd_eta_r});
    if (obj_phi_r >= rd_phi_r) begin
      dpa_nxt = obj_phi_r - rd_phi_r;
    end else begin
      dpa_nxt = rd_phi_r - obj_phi_r;
    end
  end

  // stage 2: fold at pi
  always_comb begin
    dpa_ext = FOLD_W'(dpa_r);
    fold_up = TWO_PI_QV - dpa_ext;
    fold_dn = dpa_ext - TWO_PI_QV;
    if (dpa_ext <= PI_QV) begin
      dpf_nxt = dpa_r;
    end else if (TWO_PI_QV >= dpa_ext) begin
      dpf_nxt = fold_up[PHI_W-1:0];
    end else begin
      dpf_nxt = fold_dn[PHI_W-1:0];
    end
  end

  assign de_prod = de2_r * de2_r;
  assign dist_sq = SUM_W'(de_sq_r) + SUM_W'(dp_sq_r);
  assign close   = dist_sq < SUM_W'(thr_sq_r);

  always_ff @(posedge clk) begin
    de_r    <= de_nxt;
    dpa_r   <= dpa_nxt;
    de2_r   <= de_r;
    dpf_r   <= dpf_nxt;
    de_sq_r <= de_prod[DE_SQ_W-1:0];
    dp_sq_r <= dpf_r * dpf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (v4_r && close) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign sts.busy = v1_r | v2_r | v3_r | v4_r;
  assign sts.hit  = hit_r;

endmodule

// File: hdl/gdof_ctrl.sv
// controller: list scan sequencing, list count and result register
`timescale 1ns / 1ps
module gdof_ctrl import gdof_pkg::*; #(
  parameter int MAX_KEPT = 16,
  parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_in_event,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_keep,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_overflow,
  output gdof_cmd_t         cmd,
  output logic [AW-1:0]     addr,
  input  gdof_sts_t         sts
);

  localparam int CW = $clog2(MAX_KEPT + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_keep_r, out_keep_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              room;
  logic              keep_c;
  logic              out_free;

  assign room     = cnt_r < CW'(MAX_KEPT);
  assign keep_c   = !sts.hit && room;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_keep_nxt  = out_keep_r;
    out_slot_nxt  = out_slot_r;
    out_ovf_nxt   = out_ovf_r;
    cmd           = '0;
    addr          = idx_r[AW-1:0];
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last_in_event;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r < cnt_r) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else if (!sts.busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_keep_nxt  = keep_c;
          out_slot_nxt  = keep_c ? SLOT_W'(cnt_r) : '0;
          out_ovf_nxt   = !sts.hit && !room;
          if (keep_c) begin
            cmd.wr_en = 1'b1;
            addr      = cnt_r[AW-1:0];
          end
          cnt_nxt   = last_r ? '0 : cnt_r + CW'(keep_c);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_keep_r <= out_keep_nxt;
    out_slot_r <= out_slot_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_keep     = out_keep_r;
  assign out_slot     = out_slot_r;
  assign out_overflow = out_ovf_r;

endmodule

// File: hdl/greedy_delta_r_overlap_filter_core.sv
// Greedy eta/phi overlap filter: each object is checked against the list of objects
// kept so far in its event and is kept unless its squared distance to one of them is
// below the squared threshold (azimuth difference folded at pi). One result per
// object. With n objects already kept in the event (n from 1 to MAX_KEPT) the list
// memory is read one stored object per cycle into a four-stage compare pipeline,
// which then drains before the decision; with an empty list the scan goes straight
// to the decision. The result is held in the output register. The next object
// is taken in the cycle its predecessor's result first shows, so a new object waits
// until the last one's result is out; a stalled result holds the decision and so
// the next transfer in. The threshold port is always ready; write it only while
// the block is idle.
`timescale 1ns / 1ps
module greedy_delta_r_overlap_filter_core import gdof_pkg::*; #(
  parameter int MAX_KEPT  = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ETA_W-1:0] in_eta,
  input  logic        [PHI_W-1:0] in_phi,
  input  logic                    in_last_in_event,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_keep,
  output logic [SLOT_W-1:0]       out_slot,
  output logic                    out_overflow,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic        [THR_W-1:0] cfg_min_distance
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  gdof_cmd_t     cmd;
  gdof_sts_t     sts;
  logic [AW-1:0] addr;

  assign cfg_ready = 1'b1;

  gdof_ctrl #(
    .MAX_KEPT (MAX_KEPT),
    .AW       (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_in_event (in_last_in_event),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_keep         (out_keep),
    .out_slot         (out_slot),
    .out_overflow     (out_overflow),
    .cmd              (cmd),
    .addr             (addr),
    .sts              (sts)
  );

  gdof_datapath #(
    .MAX_KEPT  (MAX_KEPT),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_eta           (in_eta),
    .in_phi           (in_phi),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_min_distance (cfg_min_distance),
    .cmd              (cmd),
    .addr             (addr),
    .sts              (sts)
  );

endmodule

// File: sim/gdof_overlap_checker.sv
// checker for the overlap filter: follows every transfer, predicts each verdict, compares
`timescale 1ns / 1ps
module gdof_overlap_checker import gdof_pkg::*; #(
  parameter int MAX_KEPT  = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [ETA_W-1:0] in_eta,
  input  logic        [PHI_W-1:0] in_phi,
  input  logic                    in_last_in_event,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_keep,
  input  logic [SLOT_W-1:0]       out_slot,
  input  logic                    out_overflow,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic        [THR_W-1:0] cfg_min_distance,
  output int                      fail_count,
  output int                      pending_results,
  output int                      objects_checked,
  output int                      kept_observed,
  output int                      overflow_observed
);

  localparam longint PI_Q =
    (longint'(PI_Q20) + (longint'(1) << (19 - FRAC_BITS))) >>> (20 - FRAC_BITS);

  typedef struct packed {
    logic              keep;
    logic [SLOT_W-1:0] slot;
    logic              overflow;
  } verdict_t;

  logic signed [ETA_W-1:0] list_eta [MAX_KEPT];
  logic        [PHI_W-1:0] list_phi [MAX_KEPT];
  int                      list_len;
  logic        [THR_W-1:0] threshold;
  verdict_t                verdict_q [$];
  int                      mismatches;
  int                      checked;
  int                      kept_n;
  int                      overflow_n;

  function automatic verdict_t admit_object(input logic signed [ETA_W-1:0] eta,
                                            input logic [PHI_W-1:0] phi,
                                            input logic last);
    verdict_t v;
    logic     hit;
    longint   de;
    longint   dp;
    longint   thr;
    v   = '0;
    hit = 1'b0;
    thr = longint'(threshold);
    for (int i = 0; i < list_len && !hit; i++) begin
      de = longint'(eta) - longint'(list_eta[i]);
      dp = longint'(phi) - longint'(list_phi[i]);
      if (dp < 0) dp = -dp;
      // azimuth folded at pi
      if (dp > PI_Q) dp = 2 * PI_Q - dp;
      hit = (de * de + dp * dp < thr * thr);
    end
    if (!hit) begin
      if (list_len < MAX_KEPT) begin
        list_eta[list_len] = eta;
        list_phi[list_len] = phi;
        v.keep = 1'b1;
        v.slot = SLOT_W'(list_len);
        list_len++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    if (last) list_len = 0;
    return v;
  endfunction

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      if (mismatches < 10)
        $display("%0t: %s of result %0d: expected %0d, got %0d",
                 $realtime, field, checked, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      list_len   = 0;
      threshold  = THR_RESET;
      verdict_q.delete();
      mismatches = 0;
      checked    = 0;
      kept_n     = 0;
      overflow_n = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing pending (keep %0d slot %0d ovf %0d)",
                     $realtime, out_keep, out_slot, out_overflow);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          compare_field("keep", int'(want.keep), int'(out_keep));
          compare_field("slot", int'(want.slot), int'(out_slot));
          compare_field("overflow", int'(want.overflow), int'(out_overflow));
        end
        checked++;
        if (out_keep) kept_n++;
        if (out_overflow) overflow_n++;
      end
      if (in_valid && !in_stall)
        verdict_q.insert(verdict_q.size(), admit_object(in_eta, in_phi, in_last_in_event));
      if (cfg_valid && cfg_ready)
        threshold = cfg_min_distance;
    end
    fail_count        <= mismatches;
    pending_results   <= verdict_q.size();
    objects_checked   <= checked;
    kept_observed     <= kept_n;
    overflow_observed <= overflow_n;
  end

endmodule

// File: sim/tb.sv
// testbench top for the overlap filter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb import gdof_pkg::*;;

  localparam int PHI_WRAP = 25736;
  localparam int PHI_MAX  = 25735;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic signed [ETA_W-1:0] in_eta           = '0;
  logic        [PHI_W-1:0] in_phi           = '0;
  logic                    in_last_in_event = 1'b0;
  logic                    out_valid;
  logic                    out_stall        = 1'b0;
  logic                    out_keep;
  logic [SLOT_W-1:0]       out_slot;
  logic                    out_overflow;
  logic                    cfg_valid        = 1'b0;
  logic                    cfg_ready;
  logic        [THR_W-1:0] cfg_min_distance = '0;

  int fail_count;
  int pending_results;
  int objects_checked;
  int kept_observed;
  int overflow_observed;

  logic calm = 1'b0;
  int   cur_thr = 1638;
  int   settings_used = 1;
  int   items_sent = 0;

  greedy_delta_r_overlap_filter_core #(
    .MAX_KEPT (16),
    .FRAC_BITS(12)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_eta          (in_eta),
    .in_phi          (in_phi),
    .in_last_in_event(in_last_in_event),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_keep        (out_keep),
    .out_slot        (out_slot),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_min_distance(cfg_min_distance)
  );

  gdof_overlap_checker #(
    .MAX_KEPT (16),
    .FRAC_BITS(12)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_eta           (in_eta),
    .in_phi           (in_phi),
    .in_last_in_event (in_last_in_event),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_keep         (out_keep),
    .out_slot         (out_slot),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_min_distance (cfg_min_distance),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .objects_checked  (objects_checked),
    .kept_observed    (kept_observed),
    .overflow_observed(overflow_observed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("** greedy_delta_r_overlap_filter_core: FAILED **");
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_object(input logic signed [ETA_W-1:0] eta,
                             input logic [PHI_W-1:0] phi,
                             input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_eta           <= eta;
    in_phi           <= phi;
    in_last_in_event <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input int thr);
    drain();
    repeat (24) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_min_distance <= THR_W'(thr);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    settings_used++;
  endtask

  // one event: many objects close to earlier ones, the rest anywhere
  task automatic run_event(input int n_obj, input logic broken);
    logic signed [ETA_W-1:0] ev_eta [24];
    logic        [PHI_W-1:0] ev_phi [24];
    int                      j;
    int                      spread;
    int                      e;
    int                      p;
    logic                    last;
    spread = 2 * cur_thr + 1;
    for (int k = 0; k < n_obj; k++) begin
      if (k > 0 && $urandom_range(0, 99) < 45) begin
        j = $urandom_range(0, k - 1);
        e = int'(ev_eta[j]) + $urandom_range(0, 2 * spread) - spread;
        p = int'(ev_phi[j]) + $urandom_range(0, 2 * spread) - spread;
        if (p < 0) p += PHI_WRAP;
        ev_eta[k] = ETA_W'(e);
        ev_phi[k] = PHI_W'(p);
      end else begin
        ev_eta[k] = ETA_W'($urandom);
        if ($urandom_range(0, 9) == 0)
          ev_phi[k] = PHI_W'($urandom_range(PHI_WRAP, 32767));
        else
          ev_phi[k] = PHI_W'($urandom_range(0, PHI_MAX));
      end
      if (broken) last = ($urandom_range(0, 7) == 0);
      else last = (k == n_obj - 1);
      send_object(ev_eta[k], ev_phi[k], last);
    end
  endtask

  initial begin
    int phase_thr [7];
    int phase_items;
    int n_obj;
    phase_thr = '{300, 32767, 0, -1, 1638, 6000, -1};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, distance on the threshold, just inside, azimuth wrap, extremes
    send_object(16'sd0, 15'd0, 1'b0);
    send_object(16'sd1638, 15'd0, 1'b0);
    send_object(16'sd1637, 15'd0, 1'b0);
    send_object(16'sh8000, 15'(PHI_MAX), 1'b0);
    send_object(16'sh8000, 15'd100, 1'b0);
    send_object(16'sd32767, 15'd32767, 1'b0);
    send_object(16'sd32767, 15'd12868, 1'b1);

    // zero threshold: list fills, then overflow
    write_threshold(0);
    for (int k = 0; k < 18; k++)
      send_object(16'sd100, 15'd200, 1'(k == 17));

    for (int ph = 0; ph < 7; ph++) begin
      write_threshold(phase_thr[ph] < 0 ? $urandom_range(1, 32766) : phase_thr[ph]);
      phase_items = 0;
      while (phase_items < 70) begin
        calm = ($urandom_range(0, 4) == 0);
        n_obj = $urandom_range(1, 22);
        run_event(n_obj, 1'($urandom_range(0, 9) == 0));
        phase_items += n_obj;
        if ($urandom_range(0, 7) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    $display("run covered %0d objects (%0d sent) over %0d threshold settings",
             objects_checked, items_sent, settings_used);
    $display("%0d objects kept, %0d overflowed on a full list", kept_observed,
             overflow_observed);
    if (fail_count == 0 && pending_results == 0) begin
      $display("** greedy_delta_r_overlap_filter_core: PASSED **");
    end else begin
      $display("** greedy_delta_r_overlap_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: greedy_delta_r_overlap_filter_core.f
hdl/gdof_pkg.sv
hdl/gdof_datapath.sv
hdl/gdof_ctrl.sv
hdl/greedy_delta_r_overlap_filter_core.sv
sim/gdof_overlap_checker.sv
sim/tb.sv
